// ----- hw/rtl/mi3x3_pkg.sv -----
// Shared constants for the 3x3 fixed-point matrix inverse.
// No dependencies; used by the interfaces, the divider pipeline and the top level.
package mi3x3_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_ENT       = 9;
    localparam int NUM_PROD      = 18;

    // Cofactor k = a[PROD_A[2k]]*a[PROD_B[2k]] - a[PROD_A[2k+1]]*a[PROD_B[2k+1]]
    localparam int PROD_A [NUM_PROD] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
    localparam int PROD_B [NUM_PROD] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

    // Determinant expands along row 0: a0*c0 + a1*c3 + a2*c6
    localparam int DET_IDX [3] = '{0, 3, 6};

endpackage

// ----- hw/rtl/mi3x3_if.sv -----
// Valid/ready channels for the matrix inverse: input matrix and result beat.
// Depends on mi3x3_pkg for default widths.
interface mi3x3_in_if #(
    parameter int WORD_BITS = mi3x3_pkg::WORD_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] a_r0c0;
    logic signed [WORD_BITS-1:0] a_r0c1;
    logic signed [WORD_BITS-1:0] a_r0c2;
    logic signed [WORD_BITS-1:0] a_r1c0;
    logic signed [WORD_BITS-1:0] a_r1c1;
    logic signed [WORD_BITS-1:0] a_r1c2;
    logic signed [WORD_BITS-1:0] a_r2c0;
    logic signed [WORD_BITS-1:0] a_r2c1;
    logic signed [WORD_BITS-1:0] a_r2c2;

    modport source (output valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
                    a_r2c0, a_r2c1, a_r2c2, input ready);
    modport sink   (input valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
                    a_r2c0, a_r2c1, a_r2c2, output ready);
endinterface

interface mi3x3_out_if #(
    parameter int WORD_BITS = mi3x3_pkg::WORD_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] inv_r0c0;
    logic signed [WORD_BITS-1:0] inv_r0c1;
    logic signed [WORD_BITS-1:0] inv_r0c2;
    logic signed [WORD_BITS-1:0] inv_r1c0;
    logic signed [WORD_BITS-1:0] inv_r1c1;
    logic signed [WORD_BITS-1:0] inv_r1c2;
    logic signed [WORD_BITS-1:0] inv_r2c0;
    logic signed [WORD_BITS-1:0] inv_r2c1;
    logic signed [WORD_BITS-1:0] inv_r2c2;
    logic                        singular;
    logic                        saturated;

    modport source (output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                    inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, singular, saturated,
                    input ready);
    modport sink   (input valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                    inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, singular, saturated,
                    output ready);
endinterface

// ----- hw/rtl/mi3x3_div_pipe.sv -----
// Nine-lane pipelined restoring divider: cofactor * 2^(2F) / det, saturate, pack result.
// Depends on mi3x3_pkg and mi3x3_out_if.
module mi3x3_div_pipe #(
    parameter int WORD_BITS = mi3x3_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = mi3x3_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [2*WORD_BITS:0]   i_cof [mi3x3_pkg::NUM_ENT],
    input  logic signed [3*WORD_BITS+2:0] i_det,
    mi3x3_out_if.source                   o_out
);
    localparam int W   = WORD_BITS;
    localparam int NE  = mi3x3_pkg::NUM_ENT;
    localparam int CW  = 2*W + 1;
    localparam int DW  = 3*W + 3;
    localparam int NW  = CW + 2*FRAC_BITS;
    localparam int QW  = NW - W;
    localparam int RW  = ((QW > DW) ? QW : DW) + 1;
    localparam int NS  = W + 2;    // prep, W steps, output
    localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS:0]   en;

    logic [RW-1:0] r_rem  [0:W][NE];
    logic [W-1:0]  r_num  [0:W][NE];
    logic [W-1:0]  r_q    [0:W][NE];
    logic          r_neg  [0:W][NE];
    logic          r_ovf  [0:W][NE];
    logic [DW-1:0] r_dm   [0:W];
    logic          r_zero [0:W];

    logic [CW-1:0] cmag [NE];
    logic [NW-1:0] nval [NE];
    logic [DW-1:0] dmag;

    logic signed [W-1:0] r_out [NE];
    logic                r_sing;
    logic                r_sat;
    logic signed [W-1:0] n_out [NE];
    logic                n_sat;

    // stage enables: a stage moves when empty or when its successor moves
    always_comb begin
        en[NS] = o_out.ready;
        for (int s = NS - 1; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end
    assign o_ready = en[0];
    assign n_vld   = {r_vld[NS-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (en[s]) begin
                    r_vld[s] <= n_vld[s];
                end
            end
        end
    end

    // prep: magnitudes, sign, high-part overflow check
    always_comb begin
        dmag = i_det[DW-1] ? DW'(-i_det) : DW'(i_det);
        for (int l = 0; l < NE; l++) begin
            cmag[l] = i_cof[l][CW-1] ? CW'(-i_cof[l]) : CW'(i_cof[l]);
            nval[l] = {cmag[l], {(2*FRAC_BITS){1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_dm[0]   <= dmag;
            r_zero[0] <= (i_det == '0);
            for (int l = 0; l < NE; l++) begin
                r_ovf[0][l] <= (RW'(nval[l][NW-1:W]) >= RW'(dmag));
                r_rem[0][l] <= RW'(nval[l][NW-1:W]);
                r_num[0][l] <= nval[l][W-1:0];
                r_q[0][l]   <= '0;
                r_neg[0][l] <= i_cof[l][CW-1] ^ i_det[DW-1];
            end
        end
    end

    // one quotient bit per stage
    for (genvar s = 1; s <= W; s++) begin : g_step
        logic [RW-1:0] rs [NE];
        logic          ge [NE];

        always_comb begin
            for (int l = 0; l < NE; l++) begin
                rs[l] = {r_rem[s-1][l][RW-2:0], r_num[s-1][l][W-1]};
                ge[l] = (rs[l] >= RW'(r_dm[s-1]));
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_dm[s]   <= r_dm[s-1];
                r_zero[s] <= r_zero[s-1];
                for (int l = 0; l < NE; l++) begin
                    r_rem[s][l] <= ge[l] ? (rs[l] - RW'(r_dm[s-1])) : rs[l];
                    r_num[s][l] <= {r_num[s-1][l][W-2:0], 1'b0};
                    r_q[s][l]   <= {r_q[s-1][l][W-2:0], ge[l]};
                    r_neg[s][l] <= r_neg[s-1][l];
                    r_ovf[s][l] <= r_ovf[s-1][l];
                end
            end
        end
    end

    // saturate and apply sign; all entries are zero when the determinant is zero
    always_comb begin
        logic [W-1:0] lim;
        logic         sat_l;
        logic [W-1:0] mag;
        n_sat = 1'b0;
        for (int l = 0; l < NE; l++) begin
            lim   = r_neg[W][l] ? LIM_NEG : LIM_POS;
            sat_l = r_ovf[W][l] || (r_q[W][l] > lim);
            mag   = sat_l ? lim : r_q[W][l];
            n_out[l] = r_neg[W][l] ? $signed(-mag) : $signed(mag);
            n_sat    = n_sat | sat_l;
            if (r_zero[W]) begin
                n_out[l] = '0;
            end
        end
        if (r_zero[W]) begin
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            r_out  <= n_out;
            r_sing <= r_zero[W];
            r_sat  <= n_sat;
        end
    end

    assign o_out.valid     = r_vld[NS-1];
    assign o_out.inv_r0c0  = r_out[0];
    assign o_out.inv_r0c1  = r_out[1];
    assign o_out.inv_r0c2  = r_out[2];
    assign o_out.inv_r1c0  = r_out[3];
    assign o_out.inv_r1c1  = r_out[4];
    assign o_out.inv_r1c2  = r_out[5];
    assign o_out.inv_r2c0  = r_out[6];
    assign o_out.inv_r2c1  = r_out[7];
    assign o_out.inv_r2c2  = r_out[8];
    assign o_out.singular  = r_sing;
    assign o_out.saturated = r_sat;

endmodule

// ----- hw/rtl/matrix3x3_inverse_unit.sv -----
// Pipeline: products, cofactors, determinant partial products, their recombination and the determinant sum,
// then the divider's prep stage, its quotient-bit steps and its output stage.
// Throughput: one matrix per cycle while no stage stalls; each stage holds its beat while its successor stalls.
// Reset: synchronous active-low i_rst_n clears all stage valid bits; data is not reset.
// Top level of the 3x3 fixed-point matrix inverse.
// Depends on mi3x3_pkg, mi3x3_if and mi3x3_div_pipe.
module matrix3x3_inverse_unit #(
    parameter int WORD_BITS = mi3x3_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = mi3x3_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mi3x3_in_if.sink     i_in,
    mi3x3_out_if.source  o_out
);
    localparam int W  = WORD_BITS;
    localparam int NE = mi3x3_pkg::NUM_ENT;
    localparam int NP = mi3x3_pkg::NUM_PROD;
    localparam int PW = 2*W;
    localparam int CW = 2*W + 1;
    localparam int DW = 3*W + 3;
    localparam int NF = 5;

    logic signed [W-1:0] a [NE];

    logic [NF-1:0] r_vld;
    logic [NF-1:0] n_vld;
    logic [NF:0]   en;
    logic          div_ready;

    logic signed [PW-1:0] r_p   [NP];
    logic signed [W-1:0]  r_m1  [3];
    logic signed [W-1:0]  r_m2  [3];
    logic signed [CW-1:0] r_c2  [NE];
    logic signed [CW-1:0] r_c3  [NE];
    logic signed [CW-1:0] r_c4  [NE];
    logic signed [CW-1:0] r_c5  [NE];
    logic signed [CW:0]   r_pl  [3];
    logic signed [CW:0]   r_ph  [3];
    logic signed [DW-1:0] r_t   [3];
    logic signed [DW-1:0] r_det;

    assign a[0] = i_in.a_r0c0;
    assign a[1] = i_in.a_r0c1;
    assign a[2] = i_in.a_r0c2;
    assign a[3] = i_in.a_r1c0;
    assign a[4] = i_in.a_r1c1;
    assign a[5] = i_in.a_r1c2;
    assign a[6] = i_in.a_r2c0;
    assign a[7] = i_in.a_r2c1;
    assign a[8] = i_in.a_r2c2;

    always_comb begin
        en[NF] = div_ready;
        for (int s = NF - 1; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end
    assign i_in.ready = en[0];
    assign n_vld      = {r_vld[NF-2:0], i_in.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NF; s++) begin
                if (en[s]) begin
                    r_vld[s] <= n_vld[s];
                end
            end
        end
    end

    // products
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int i = 0; i < NP; i++) begin
                r_p[i] <= a[mi3x3_pkg::PROD_A[i]] * a[mi3x3_pkg::PROD_B[i]];
            end
            for (int k = 0; k < 3; k++) begin
                r_m1[k] <= a[k];
            end
        end
    end

    // cofactors
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int k = 0; k < NE; k++) begin
                r_c2[k] <= CW'(r_p[2*k]) - CW'(r_p[2*k+1]);
            end
            r_m2 <= r_m1;
        end
    end

    // determinant partial products: cofactor split into unsigned low word and signed high part
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int k = 0; k < 3; k++) begin
                r_pl[k] <= r_m2[k] * $signed({1'b0, r_c2[mi3x3_pkg::DET_IDX[k]][W-1:0]});
                r_ph[k] <= r_m2[k] * $signed(r_c2[mi3x3_pkg::DET_IDX[k]][CW-1:W]);
            end
            r_c3 <= r_c2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            for (int k = 0; k < 3; k++) begin
                r_t[k] <= (DW'(r_ph[k]) <<< W) + DW'(r_pl[k]);
            end
            r_c4 <= r_c3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_det <= r_t[0] + r_t[1] + r_t[2];
            r_c5  <= r_c4;
        end
    end

    mi3x3_div_pipe #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[NF-1]),
        .o_ready (div_ready),
        .i_cof   (r_c5),
        .i_det   (r_det),
        .o_out   (o_out)
    );

endmodule

// ----- hw/rtl/mi3x3_chk.sv -----
// Port-level checker for matrix3x3_inverse_unit, attached by bind.
// Depends on mi3x3_pkg for default widths.
module mi3x3_chk #(
    parameter int WORD_BITS = mi3x3_pkg::WORD_BITS_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 i_ready,
    input logic                 i_sing,
    input logic                 i_sat,
    input logic [WORD_BITS-1:0] i_e0,
    input logic [WORD_BITS-1:0] i_e4,
    input logic [WORD_BITS-1:0] i_e8
);
    // nothing leaves the block in the cycle after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result beat right after reset");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_sing) |-> (i_e0 == '0 && i_e4 == '0 && i_e8 == '0))
        else $error("singular beat with nonzero entries");

    a_sing_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !(i_sing && i_sat))
        else $error("singular and saturated together");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_e0) && $stable(i_sing)))
        else $error("stalled beat changed");

endmodule

bind matrix3x3_inverse_unit mi3x3_chk #(.WORD_BITS(WORD_BITS)) u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_sing  (o_out.singular),
    .i_sat   (o_out.saturated),
    .i_e0    (o_out.inv_r0c0),
    .i_e4    (o_out.inv_r1c1),
    .i_e8    (o_out.inv_r2c2)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for matrix3x3_inverse_unit: valid/ready beats of 3x3 Q16.16 matrices in,
// inverse entries plus singular/saturated flags out, checked against an exact local predictor.
// Depends on mi3x3_pkg, mi3x3_if and the RTL of the inverse unit.
module testbench;

    localparam int WB = mi3x3_pkg::WORD_BITS_DEF;
    localparam int FB = mi3x3_pkg::FRAC_BITS_DEF;
    localparam int NUM_ENT = mi3x3_pkg::NUM_ENT;
    localparam int XW = 4 * WB + 2 * FB + 32;  // exact room for det and shifted cofactor
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = WB + 20;

    typedef logic signed [WB-1:0] word_t;
    typedef logic signed [XW-1:0] wide_t;
    typedef struct {word_t e [NUM_ENT];} matrix_t;
    typedef struct {word_t e [NUM_ENT]; logic singular; logic saturated;} inverse_t;
    typedef enum int {GEN_FULL, GEN_SMALL, GEN_SINGULAR, GEN_TINY} gen_kind_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mi3x3_in_if  #(.WORD_BITS(WB)) mat_if ();
    mi3x3_out_if #(.WORD_BITS(WB)) inv_if ();

    matrix3x3_inverse_unit #(.WORD_BITS(WB), .FRAC_BITS(FB)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (mat_if),
        .o_out  (inv_if)
    );

    always #4 i_clk = ~i_clk;

    inverse_t expected_inverses[$];
    int err_count = 0;
    int beats_in = 0;
    int beats_out = 0;
    int singular_seen = 0;
    int saturated_seen = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    bit hold_request = 1'b0;
    int cycle_count = 0;

    // ---------------- predictor ----------------
    function automatic wide_t cofactor(word_t a, word_t b, word_t c, word_t d);
        wide_t wa, wb2, wc, wd;
        wa = a; wb2 = b; wc = c; wd = d;
        return wa * wb2 - wc * wd;
    endfunction

    function automatic inverse_t invert_matrix(matrix_t m);
        inverse_t r;
        wide_t cof [NUM_ENT];
        wide_t det, num, q, w0, w1, w2;
        wide_t max_v, min_v;
        max_v = (wide_t'(1) <<< (WB - 1)) - 1;
        min_v = -(wide_t'(1) <<< (WB - 1));
        cof[0] = cofactor(m.e[4], m.e[8], m.e[5], m.e[7]);
        cof[1] = cofactor(m.e[2], m.e[7], m.e[1], m.e[8]);
        cof[2] = cofactor(m.e[1], m.e[5], m.e[2], m.e[4]);
        cof[3] = cofactor(m.e[5], m.e[6], m.e[3], m.e[8]);
        cof[4] = cofactor(m.e[0], m.e[8], m.e[2], m.e[6]);
        cof[5] = cofactor(m.e[2], m.e[3], m.e[0], m.e[5]);
        cof[6] = cofactor(m.e[3], m.e[7], m.e[4], m.e[6]);
        cof[7] = cofactor(m.e[1], m.e[6], m.e[0], m.e[7]);
        cof[8] = cofactor(m.e[0], m.e[4], m.e[1], m.e[3]);
        w0 = m.e[0]; w1 = m.e[1]; w2 = m.e[2];
        det = w0 * cof[0] + w1 * cof[3] + w2 * cof[6];
        r.singular = (det == 0);
        r.saturated = 1'b0;
        for (int i = 0; i < NUM_ENT; i++) begin
            if (det == 0) begin
                r.e[i] = '0;
            end else begin
                num = cof[i] <<< (2 * FB);
                q = num / det;  // signed divide truncates toward zero
                if (q > max_v) begin
                    q = max_v;
                    r.saturated = 1'b1;
                end else if (q < min_v) begin
                    q = min_v;
                    r.saturated = 1'b1;
                end
                r.e[i] = q[WB-1:0];
            end
        end
        return r;
    endfunction

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        inverse_t got, want;
        if (i_rst_n && inv_if.valid && inv_if.ready) begin
            got.e[0] = inv_if.inv_r0c0; got.e[1] = inv_if.inv_r0c1; got.e[2] = inv_if.inv_r0c2;
            got.e[3] = inv_if.inv_r1c0; got.e[4] = inv_if.inv_r1c1; got.e[5] = inv_if.inv_r1c2;
            got.e[6] = inv_if.inv_r2c0; got.e[7] = inv_if.inv_r2c1; got.e[8] = inv_if.inv_r2c2;
            got.singular = inv_if.singular;
            got.saturated = inv_if.saturated;
            beats_out++;
            if (got.singular) singular_seen++;
            if (got.saturated) saturated_seen++;
            if (expected_inverses.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result beat, entry r0c0 %h", $time, got.e[0]);
            end else begin
                want = expected_inverses.pop_front();
                for (int i = 0; i < NUM_ENT; i++)
                    if (got.e[i] !== want.e[i]) begin
                        err_count++;
                        $display("%0t: inv entry %0d expected %h actual %h",
                                 $time, i, want.e[i], got.e[i]);
                    end
                if (got.singular !== want.singular) begin
                    err_count++;
                    $display("%0t: singular expected %b actual %b",
                             $time, want.singular, got.singular);
                end
                if (got.saturated !== want.saturated) begin
                    err_count++;
                    $display("%0t: saturated expected %b actual %b",
                             $time, want.saturated, got.saturated);
                end
            end
        end
    end

    // ---------------- receiver ready, with long hold-off on request ----------------
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            inv_if.ready <= 1'b0;
        end else begin
            inv_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_inverses.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_matrix(matrix_t m);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            mat_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        mat_if.valid  <= 1'b1;
        mat_if.a_r0c0 <= m.e[0]; mat_if.a_r0c1 <= m.e[1]; mat_if.a_r0c2 <= m.e[2];
        mat_if.a_r1c0 <= m.e[3]; mat_if.a_r1c1 <= m.e[4]; mat_if.a_r1c2 <= m.e[5];
        mat_if.a_r2c0 <= m.e[6]; mat_if.a_r2c1 <= m.e[7]; mat_if.a_r2c2 <= m.e[8];
        do @(posedge i_clk); while (!mat_if.ready);
        expected_inverses.push_back(invert_matrix(m));
        beats_in++;
        @(negedge i_clk);
    endtask

    function automatic matrix_t diag_matrix(word_t d0, word_t d1, word_t d2);
        matrix_t m;
        foreach (m.e[i]) m.e[i] = '0;
        m.e[0] = d0; m.e[4] = d1; m.e[8] = d2;
        return m;
    endfunction

    function automatic word_t small_q(int span);
        return word_t'($signed($urandom_range(2 * span, 0)) - span);
    endfunction

    function automatic matrix_t random_matrix(gen_kind_t kind);
        matrix_t m;
        int src, dst, k;
        foreach (m.e[i]) begin
            case (kind)
                GEN_FULL: m.e[i] = $urandom;
                GEN_TINY: m.e[i] = small_q(8);
                default:  m.e[i] = small_q(4 << FB);  // within +/-4.0
            endcase
        end
        if (kind == GEN_SINGULAR) begin
            // make one row a small multiple of another
            src = $urandom_range(2);
            dst = (src + $urandom_range(1, 2)) % 3;
            k = $urandom_range(4) - 2;
            for (int c = 0; c < 3; c++) m.e[3 * dst + c] = m.e[3 * src + c] * k;
        end
        return m;
    endfunction

    task automatic test_directed();
        localparam word_t ONE = word_t'(1) <<< FB;
        localparam word_t WMAX = {1'b0, {(WB - 1){1'b1}}};
        localparam word_t WMIN = {1'b1, {(WB - 1){1'b0}}};
        matrix_t m;
        send_matrix(diag_matrix(ONE, ONE, ONE));             // identity
        send_matrix(diag_matrix(2 * ONE, -4 * ONE, ONE / 2)); // scaled diagonal
        send_matrix(diag_matrix('0, '0, '0));                // zero matrix, singular
        send_matrix(diag_matrix(1, 1, 1));                   // tiny det, saturates high
        send_matrix(diag_matrix(-1, 1, 1));                  // saturates low and high
        send_matrix(diag_matrix(WMAX, WMAX, WMAX));
        send_matrix(diag_matrix(WMIN, WMIN, WMIN));
        send_matrix(diag_matrix(3 * ONE, 3 * ONE, -3 * ONE)); // truncation of 1/3 both signs
        foreach (m.e[i]) m.e[i] = WMAX;
        send_matrix(m);                                      // all equal rows, singular
        foreach (m.e[i]) m.e[i] = WMIN;
        send_matrix(m);
        foreach (m.e[i]) m.e[i] = -1;
        send_matrix(m);
        foreach (m.e[i]) m.e[i] = '0;
        m.e[1] = ONE; m.e[5] = ONE; m.e[6] = ONE;            // permutation
        send_matrix(m);
        m.e[1] = WMIN; m.e[5] = WMAX; m.e[6] = WMIN;
        send_matrix(m);
        foreach (m.e[i]) m.e[i] = word_t'(i + 1) * ONE;      // rank two
        send_matrix(m);
        m.e[8] = 10 * ONE;
        send_matrix(m);
        foreach (m.e[i]) m.e[i] = (i % 2) ? WMAX : WMIN;
        send_matrix(m);
        foreach (m.e[i]) m.e[i] = (i % 4 == 0) ? WMAX : 1;
        send_matrix(m);
    endtask

    task automatic test_random(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 35)      send_matrix(random_matrix(GEN_SMALL));
            else if (pick < 65) send_matrix(random_matrix(GEN_FULL));
            else if (pick < 85) send_matrix(random_matrix(GEN_SINGULAR));
            else                send_matrix(random_matrix(GEN_TINY));
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // no beat on offer while the hold-off is armed
        mat_if.valid <= 1'b0;
        @(posedge i_clk);
        hold_request = 1'b1;
        @(negedge i_clk);
        test_random(120);
    endtask

    initial begin
        mat_if.valid = 1'b0;
        mat_if.a_r0c0 = '0; mat_if.a_r0c1 = '0; mat_if.a_r0c2 = '0;
        mat_if.a_r1c0 = '0; mat_if.a_r1c1 = '0; mat_if.a_r1c2 = '0;
        mat_if.a_r2c0 = '0; mat_if.a_r2c1 = '0; mat_if.a_r2c2 = '0;
        inv_if.ready = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        send_idle_pct = 22; recv_idle_pct = 69;
        test_random(580);
        send_idle_pct = 69; recv_idle_pct = 22;
        test_random(580);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(480);
        test_backpressure();
        send_idle_pct = 0; recv_idle_pct = 30;

        mat_if.valid <= 1'b0;
        while (expected_inverses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d matrices in, %0d inverses out (%0d singular, %0d saturated),",
                 beats_in, beats_out, singular_seen, saturated_seen);
        $display("under sender/receiver idling mixes and a long output stall; %0d mismatches.",
                 err_count);
        if (err_count == 0 && expected_inverses.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
